### sv/hrd_pkg.sv
// Shared types, codes and constants of the H.263+ RTP depacketiser.
`timescale 1ns / 1ps

package hrd_pkg;

  localparam int unsigned PADDING = 16;
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [20:0] MAX_FRAME_RESET = 21'd1048576;
  localparam logic [10:0] IDLE_INDEX = 11'd2047;
  localparam logic [10:0] LAST_COUNT = 11'd2046;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_BEGIN = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_HEADER   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] offset;
    logic [7:0]  out_byte;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                last_sel;
    status_t                   status;
    logic [20:0]               frame_length;
    logic [6:0]                header_length;
    logic [2:0]                header_end_bits;
  } bundle_t;

endpackage

### sv/hrd_if.sv
// Request channel interfaces for payload bytes and results.
`timescale 1ns / 1ps

interface hrd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [10:0] packet_length;

  modport source (
    output valid, op, data_byte, first_byte, last_byte, packet_length,
    input  ready
  );
  modport sink (
    input  valid, op, data_byte, first_byte, last_byte, packet_length,
    output ready
  );
endinterface

interface hrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [19:0] offset;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [20:0] frame_length;
  logic [6:0]  header_length;
  logic [2:0]  header_end_bits;
  logic        run_last;

  modport source (
    output valid, kind, offset, out_byte, status, frame_length, header_length,
           header_end_bits, run_last,
    input  ready
  );
  modport sink (
    input  valid, kind, offset, out_byte, status, frame_length, header_length,
           header_end_bits, run_last,
    output ready
  );
endinterface

### sv/hrd_core.sv
// Input register, packet state and per-byte decode into a bundle of results.
`timescale 1ns / 1ps

module hrd_core (
  input  logic             clk,
  input  logic             rst,
  hrd_in_if.sink           item,
  input  logic             cfg_we,
  input  logic [20:0]      cfg_wdata,
  output hrd_pkg::bundle_t bundle,
  output logic             bundle_valid,
  input  logic             bundle_ready
);

  localparam logic [20:0] PAD = 21'(hrd_pkg::PADDING);

  logic              irv;
  logic              ir_op;
  logic [7:0]        ir_byte;
  logic              ir_first;
  logic              ir_last;
  logic [10:0]       ir_len;

  logic [20:0]       limit;
  logic [20:0]       frame_position, frame_position_next;
  logic [10:0]       byte_index, byte_index_next;
  logic              flag_p, flag_p_next;
  logic              flag_v, flag_v_next;
  logic [5:0]        extra_header_length, extra_header_length_next;
  logic [2:0]        saved_end_bits, saved_end_bits_next;
  hrd_pkg::status_t  packet_verdict, packet_verdict_next;
  logic [6:0]        stored_header_length, stored_header_length_next;

  logic              advance;
  logic [1:0]        n_results;
  hrd_pkg::result_t [hrd_pkg::MAX_RESULTS-1:0] res;

  assign advance    = irv && bundle_ready;
  assign item.ready = !irv || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      irv <= 1'b0;
    end else if (item.valid && item.ready) begin
      irv <= 1'b1;
    end else if (advance) begin
      irv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      ir_op    <= item.op;
      ir_byte  <= item.data_byte;
      ir_first <= item.first_byte;
      ir_last  <= item.last_byte;
      ir_len   <= item.packet_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hrd_pkg::MAX_FRAME_RESET - PAD;
    end else if (cfg_we) begin
      limit <= (cfg_wdata > PAD) ? cfg_wdata - PAD : 21'd0;
    end
  end

  always_comb begin
    logic [10:0]       idx;
    logic              zeros;
    logic [5:0]        plen;
    logic [10:0]       hdr;
    logic [10:0]       rem;
    logic [22:0]       need;
    logic [10:0]       hoff;
    hrd_pkg::status_t  verdict;

    frame_position_next       = frame_position;
    byte_index_next           = byte_index;
    flag_p_next               = flag_p;
    flag_v_next               = flag_v;
    extra_header_length_next  = extra_header_length;
    saved_end_bits_next       = saved_end_bits;
    packet_verdict_next       = packet_verdict;
    stored_header_length_next = stored_header_length;
    n_results                 = 2'd0;
    res                       = '0;
    idx                       = byte_index;
    zeros                     = 1'b0;
    plen                      = 6'd0;
    hdr                       = flag_v ? 11'd3 : 11'd2;
    rem                       = 11'd0;
    need                      = 23'd0;
    hoff                      = 11'd0;
    verdict                   = packet_verdict;

    if (ir_op == hrd_pkg::OP_BEGIN) begin
      frame_position_next       = 21'd0;
      stored_header_length_next = 7'd0;
    end else if (ir_first || byte_index != hrd_pkg::IDLE_INDEX) begin
      if (ir_first) begin
        idx     = 11'd0;
        verdict = hrd_pkg::ST_OK;
      end
      if (idx == 11'd0) begin
        flag_p_next              = ir_byte[2];
        flag_v_next              = ir_byte[1];
        extra_header_length_next = {ir_byte[0], 5'd0};
        if (ir_len < 11'd3) begin
          verdict = hrd_pkg::ST_SHORT;
        end else if (ir_last) begin
          verdict = hrd_pkg::ST_HEADER;
        end
      end else if (idx == 11'd1) begin
        if (verdict == hrd_pkg::ST_OK) begin
          plen = {extra_header_length[5], ir_byte[7:3]};
          extra_header_length_next = plen;
          if (ir_len < 11'd3) begin
            verdict = hrd_pkg::ST_SHORT;
          end else if (plen != 6'd0 && ir_len < 11'(plen) + hdr) begin
            verdict = hrd_pkg::ST_HEADER;
          end else begin
            rem = ir_len - 11'(plen) - hdr;
            if (plen != 6'd0) begin
              stored_header_length_next = 7'(plen) + 7'd2;
              saved_end_bits_next       = ir_byte[2:0];
            end
            need = 23'(frame_position) + (flag_p ? 23'd2 : 23'd0) + 23'(rem);
            if (need > 23'(limit)) begin
              verdict = hrd_pkg::ST_OVERFLOW;
            end else if (flag_p) begin
              zeros = 1'b1;
            end
          end
        end
        if (zeros) begin
          res[0].kind         = hrd_pkg::KIND_FRAME;
          res[0].offset       = frame_position[19:0];
          res[1].kind         = hrd_pkg::KIND_FRAME;
          res[1].offset       = frame_position[19:0] + 20'd1;
          n_results           = 2'd2;
          frame_position_next = frame_position + 21'd2;
        end
      end else if (verdict == hrd_pkg::ST_OK && idx < ir_len) begin
        if (flag_v && idx == 11'd2) begin
          n_results = 2'd0;
        end else if (idx < hdr + 11'(extra_header_length)) begin
          hoff            = idx - hdr + 11'd2;
          res[0].kind     = hrd_pkg::KIND_HEADER;
          res[0].offset   = 20'(hoff);
          res[0].out_byte = ir_byte;
          n_results       = 2'd1;
        end else begin
          res[0].kind         = hrd_pkg::KIND_FRAME;
          res[0].offset       = frame_position[19:0];
          res[0].out_byte     = ir_byte;
          n_results           = 2'd1;
          frame_position_next = frame_position + 21'd1;
        end
      end

      if (ir_last) begin
        res[n_results].kind = hrd_pkg::KIND_STATUS;
        n_results           = n_results + 2'd1;
        byte_index_next     = hrd_pkg::IDLE_INDEX;
      end else if (idx < hrd_pkg::LAST_COUNT) begin
        byte_index_next = idx + 11'd1;
      end else begin
        byte_index_next = idx;
      end
      packet_verdict_next = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position       <= 21'd0;
      byte_index           <= 11'd0;
      flag_p               <= 1'b0;
      flag_v               <= 1'b0;
      extra_header_length  <= 6'd0;
      saved_end_bits       <= 3'd0;
      packet_verdict       <= hrd_pkg::ST_OK;
      stored_header_length <= 7'd0;
    end else if (advance) begin
      frame_position       <= frame_position_next;
      byte_index           <= byte_index_next;
      flag_p               <= flag_p_next;
      flag_v               <= flag_v_next;
      extra_header_length  <= extra_header_length_next;
      saved_end_bits       <= saved_end_bits_next;
      packet_verdict       <= packet_verdict_next;
      stored_header_length <= stored_header_length_next;
    end
  end

  assign bundle_valid           = advance && (n_results != 2'd0);
  assign bundle.res             = res;
  assign bundle.last_sel        = n_results - 2'd1;
  assign bundle.status          = packet_verdict_next;
  assign bundle.frame_length    = frame_position_next;
  assign bundle.header_length   = stored_header_length_next;
  assign bundle.header_end_bits = saved_end_bits_next;

endmodule

### sv/hrd_serializer.sv
// Result register that delivers a bundle of results one request at a time.
`timescale 1ns / 1ps

module hrd_serializer (
  input  logic             clk,
  input  logic             rst,
  input  hrd_pkg::bundle_t bundle,
  input  logic             bundle_valid,
  output logic             bundle_ready,
  hrd_out_if.source        result
);

  hrd_pkg::bundle_t held;
  logic             held_valid;
  logic [1:0]       sel;
  logic             at_last;
  hrd_pkg::result_t cur;

  assign at_last      = (sel == held.last_sel);
  assign bundle_ready = !held_valid || (result.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      sel        <= 2'd0;
    end else if (bundle_valid && bundle_ready) begin
      held_valid <= 1'b1;
      sel        <= 2'd0;
    end else if (held_valid && result.ready) begin
      if (at_last) begin
        held_valid <= 1'b0;
      end else begin
        sel <= sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_valid && bundle_ready) begin
      held <= bundle;
    end
  end

  assign cur                    = held.res[sel];
  assign result.valid           = held_valid;
  assign result.kind            = cur.kind;
  assign result.offset          = cur.offset;
  assign result.out_byte        = cur.out_byte;
  assign result.status          = held.status;
  assign result.frame_length    = held.frame_length;
  assign result.header_length   = held.header_length;
  assign result.header_end_bits = held.header_end_bits;
  assign result.run_last        = at_last;

endmodule

### sv/h263_rtp_depacketizer.sv
// Top level of the H.263+ RTP payload depacketiser.
`timescale 1ns / 1ps

// A new payload byte or begin-frame request is taken in every cycle while the
// result side keeps up. Each byte is decoded combinationally from its input
// register, and the up to three results it causes are delivered one per cycle
// while the result side is ready, from a result register, so the first result
// of a request can be taken once it has passed both registers. An item gives
// a run of results: none for a begin-frame request or a byte that emits nothing,
// one for an ordinary byte, one more for the status on a packet's last byte, and
// up to three on the second byte of a packet that inserts a start code. The
// frame limit is the written capacity less 16 bytes of padding, floored at zero.

module h263_rtp_depacketizer (
  input  logic        clk,
  input  logic        rst,
  hrd_in_if.sink      item,
  hrd_out_if.source   result,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata
);

  hrd_pkg::bundle_t bundle;
  logic             bundle_valid;
  logic             bundle_ready;

  hrd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready)
  );

  hrd_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready),
    .result       (result)
  );

endmodule

### sv/hrd_checker.sv
// Port-level assertions on the depacketiser, bound to its top level.
`timescale 1ns / 1ps

module hrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [19:0] offset,
  input logic [7:0]  out_byte,
  input logic [1:0]  status,
  input logic        run_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(offset)
      && $stable(out_byte))
    else $error("Stalled result changed.");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid straight after reset.");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hrd_pkg::KIND_STATUS |-> run_last)
    else $error("Status result is not the last of its run.");

  a_bytes_accepted: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != hrd_pkg::KIND_STATUS |-> status == hrd_pkg::ST_OK)
    else $error("Byte emitted for a rejected packet.");

  a_header_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hrd_pkg::KIND_HEADER |-> offset >= 20'd2 && offset <= 20'd65)
    else $error("Picture header index out of range.");

endmodule

bind h263_rtp_depacketizer hrd_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .kind      (result.kind),
  .offset    (result.offset),
  .out_byte  (result.out_byte),
  .status    (result.status),
  .run_last  (result.run_last)
);
